// ----- src/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and hex helpers shared by the percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Most decoded bytes one input byte can cause.
    localparam int ENTRY_SLOTS = 3;
    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // One queue entry: the bytes one input byte produced, slot 0 first.
    typedef struct packed {
        logic [1:0]                  cnt;
        logic [ENTRY_SLOTS-1:0][7:0] bytes;
        logic                        last;
    } t_entry;

    typedef enum logic [2:0] {
        PEND_NONE  = 3'b001,
        PEND_PCT   = 3'b010,
        PEND_DIGIT = 3'b100
    } t_pend;

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = (b >= 8'h30 && b <= 8'h39) ||
                 (b >= 8'h61 && b <= 8'h66) ||
                 (b >= 8'h41 && b <= 8'h46);
    endfunction

    // Value of a hex digit; zero for any other byte.
    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b - 8'h30;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = b - 8'h61 + 8'd10;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = b - 8'h41 + 8'd10;
        end
        hex_nibble = v[3:0];
    endfunction

endpackage

// ----- src/url_percent_decoder_core.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// Streaming form-urlencoded decoder: plus to space, %XX to one byte, broken
// escapes passed through, pending bytes flushed at the end of a string.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_in_item  (byte, last)
//   out     | output    | o_out_valid / i_out_stall| o_out_item (byte, last)
//
// One input byte is taken per cycle while the entry queue has room.
// Each byte yields zero to three decoded bytes; the back end drains one
// decoded byte per cycle unless stalled, so bursts of two or three hold the
// input briefly. Bytes pass through the queue memory to the output register.
// Reset is synchronous, active low, and drops any pending escape.
// o_in_stall is registered queue-full and never depends on i_in_valid.
// ----------------------------------------------------------------------------
module url_percent_decoder_core #(
    parameter int QDEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  upd_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output upd_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    upd_pkg::t_entry entry;
    upd_pkg::t_entry head;

    assign o_in_stall = q_full;

    upd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (entry)
    );

    upd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- src/upd_front.sv -----
// ----------------------------------------------------------------------------
// upd_front
// Accepts raw bytes, tracks a pending escape and turns each byte that yields
// output into one queue entry holding up to three decoded bytes.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  upd_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_push,
    output upd_pkg::t_entry   o_entry
);

    upd_pkg::t_pend r_pend;
    upd_pkg::t_pend n_pend;
    logic [7:0]     r_pend_char;
    logic [7:0]     n_pend_char;
    logic           accept;

    assign accept = i_in_valid && !i_q_full;

    always_comb begin
        logic [7:0] b;
        logic       hex;
        logic       feed;
        logic [1:0] k;
        b           = i_in_item.in_byte;
        hex         = upd_pkg::is_hex(b);
        feed        = 1'b0;
        k           = 2'd0;
        n_pend      = r_pend;
        n_pend_char = r_pend_char;
        o_entry     = '0;
        case (r_pend)
            upd_pkg::PEND_PCT: begin
                if (hex) begin
                    n_pend      = upd_pkg::PEND_DIGIT;
                    n_pend_char = b;
                end else begin
                    o_entry.bytes[0] = upd_pkg::CH_PERCENT;
                    k                = 2'd1;
                    feed             = 1'b1;
                end
            end
            upd_pkg::PEND_DIGIT: begin
                if (hex) begin
                    o_entry.bytes[0] = {upd_pkg::hex_nibble(r_pend_char),
                                        upd_pkg::hex_nibble(b)};
                    k                = 2'd1;
                    n_pend           = upd_pkg::PEND_NONE;
                end else begin
                    // Broken escape: emit the percent and the held digit.
                    o_entry.bytes[0] = upd_pkg::CH_PERCENT;
                    o_entry.bytes[1] = r_pend_char;
                    k                = 2'd2;
                    feed             = 1'b1;
                end
            end
            default: begin
                feed = 1'b1;
            end
        endcase

        if (feed) begin
            n_pend = upd_pkg::PEND_NONE;
            if (b == upd_pkg::CH_PERCENT) begin
                n_pend = upd_pkg::PEND_PCT;
            end else begin
                for (int i = 0; i < upd_pkg::ENTRY_SLOTS; i++) begin
                    if (k == 2'(i)) begin
                        o_entry.bytes[i] = (b == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : b;
                    end
                end
                k = k + 2'd1;
            end
        end

        // Flush whatever is still pending at the end of the string.
        if (i_in_item.in_last) begin
            if (n_pend == upd_pkg::PEND_PCT || n_pend == upd_pkg::PEND_DIGIT) begin
                for (int i = 0; i < upd_pkg::ENTRY_SLOTS; i++) begin
                    if (k == 2'(i)) begin
                        o_entry.bytes[i] = upd_pkg::CH_PERCENT;
                    end
                end
                k = k + 2'd1;
            end
            if (n_pend == upd_pkg::PEND_DIGIT) begin
                for (int i = 0; i < upd_pkg::ENTRY_SLOTS; i++) begin
                    if (k == 2'(i)) begin
                        o_entry.bytes[i] = n_pend_char;
                    end
                end
                k = k + 2'd1;
            end
            n_pend = upd_pkg::PEND_NONE;
        end

        o_entry.cnt  = k;
        o_entry.last = i_in_item.in_last;
    end

    assign o_push = accept && (o_entry.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= upd_pkg::PEND_NONE;
        end else if (accept) begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_char <= n_pend_char;
        end
    end

endmodule

// ----- src/upd_queue.sv -----
// ----------------------------------------------------------------------------
// upd_queue
// Small FIFO of decoded entries between the front and the back.
// ----------------------------------------------------------------------------
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  upd_pkg::t_entry i_entry,
    input  logic            i_pop,
    output upd_pkg::t_entry o_head,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    upd_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- src/upd_back.sv -----
// ----------------------------------------------------------------------------
// upd_back
// Walks the head entry one byte per cycle, when not stalled, into the output register.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  upd_pkg::t_entry    i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    output upd_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    logic [1:0]         r_idx;
    logic               r_out_valid;
    upd_pkg::t_out_item r_out_item;
    logic               load;
    logic               at_end;
    logic [7:0]         sel_byte;

    assign load   = !i_empty && (!r_out_valid || !i_out_stall);
    assign at_end = (r_idx == i_head.cnt - 2'd1);
    assign o_pop  = load && at_end;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.bytes[0];
            2'd1:    sel_byte = i_head.bytes[1];
            2'd2:    sel_byte = i_head.bytes[2];
            default: sel_byte = i_head.bytes[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= at_end ? 2'd0 : r_idx + 2'd1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item.out_byte <= sel_byte;
            r_out_item.out_last <= i_head.last && at_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- tb/tb_url_percent_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_url_percent_decoder_core
// Drives encoded strings into the percent decoder and checks every decoded
// byte and end mark against a predictor kept in step with accepted input.
// Directed strings cover plus, escapes in both letter cases, broken escapes
// and flushes at end of string; random strings follow with random idle gaps
// on the input and random stall on the output.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder_core;

    localparam int RANDOM_ITEMS = 230;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               in_valid    = 1'b0;
    upd_pkg::t_in_item  in_item     = '0;
    logic               out_stall   = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    upd_pkg::t_out_item o_out_item;

    upd_pkg::t_in_item  item_q[$];
    bit                 hold_q[$];
    upd_pkg::t_out_item decoded_q[$];
    logic [7:0]         step_q[$];

    upd_pkg::t_pend pend_state = upd_pkg::PEND_NONE;
    logic [7:0]     pend_digit = 8'h00;

    int err_cnt    = 0;
    int gap_left   = 0;
    int calm_in    = 0;
    int stall_left = 0;
    int calm_out   = 0;
    int idle_cyc   = 0;

    url_percent_decoder_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_item  (in_item),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .i_out_stall(out_stall)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int digit_value(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'("0");
        if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void plain_byte(input logic [7:0] b);
        if (b == upd_pkg::CH_PERCENT) begin
            pend_state = upd_pkg::PEND_PCT;
        end else if (b == upd_pkg::CH_PLUS) begin
            step_q.insert(step_q.size(), upd_pkg::CH_SPACE);
        end else begin
            step_q.insert(step_q.size(), b);
        end
    endfunction

    function automatic void decode_item(input upd_pkg::t_in_item it);
        int                 dv;
        int                 hi;
        upd_pkg::t_out_item r;
        dv = digit_value(it.in_byte);
        step_q.delete();
        case (pend_state)
            upd_pkg::PEND_PCT: begin
                if (dv >= 0) begin
                    pend_digit = it.in_byte;
                    pend_state = upd_pkg::PEND_DIGIT;
                end else begin
                    pend_state = upd_pkg::PEND_NONE;
                    step_q.insert(step_q.size(), upd_pkg::CH_PERCENT);
                    plain_byte(it.in_byte);
                end
            end
            upd_pkg::PEND_DIGIT: begin
                pend_state = upd_pkg::PEND_NONE;
                if (dv >= 0) begin
                    hi = digit_value(pend_digit);
                    step_q.insert(step_q.size(), {hi[3:0], dv[3:0]});
                end else begin
                    step_q.insert(step_q.size(), upd_pkg::CH_PERCENT);
                    step_q.insert(step_q.size(), pend_digit);
                    plain_byte(it.in_byte);
                end
            end
            default: begin
                pend_state = upd_pkg::PEND_NONE;
                plain_byte(it.in_byte);
            end
        endcase
        if (it.in_last) begin
            // flush a dangling escape literally
            if (pend_state != upd_pkg::PEND_NONE) begin
                step_q.insert(step_q.size(), upd_pkg::CH_PERCENT);
            end
            if (pend_state == upd_pkg::PEND_DIGIT) begin
                step_q.insert(step_q.size(), pend_digit);
            end
            pend_state = upd_pkg::PEND_NONE;
        end
        foreach (step_q[i]) begin
            r.out_byte = step_q[i];
            r.out_last = it.in_last && (i == step_q.size() - 1);
            decoded_q.insert(decoded_q.size(), r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] b, input bit last, input bit hold);
        upd_pkg::t_in_item it;
        it.in_byte = b;
        it.in_last = last;
        item_q.insert(item_q.size(), it);
        hold_q.insert(hold_q.size(), hold);
    endfunction

    function automatic void add_text(input string s, input bit last);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i], last && (i == s.len() - 1), 1'b0);
        end
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'(int'("0") + v);
        if ($urandom_range(0, 1) == 1) return 8'(int'("a") + v - 10);
        return 8'(int'("A") + v - 10);
    endfunction

    function automatic void add_random_string(input bit hold);
        logic [7:0] s[$];
        int         len;
        int         pick;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                s.insert(s.size(), upd_pkg::CH_PERCENT);
                s.insert(s.size(), hex_char());
                s.insert(s.size(), hex_char());
            end else if (pick < 45) begin
                s.insert(s.size(), upd_pkg::CH_PERCENT);
                s.insert(s.size(), hex_char());
            end else if (pick < 55) begin
                s.insert(s.size(), upd_pkg::CH_PERCENT);
            end else if (pick < 65) begin
                s.insert(s.size(), upd_pkg::CH_PLUS);
            end else begin
                s.insert(s.size(), 8'($urandom_range(0, 255)));
            end
        end
        foreach (s[i]) begin
            add_byte(s[i], i == s.size() - 1, hold && (i == 0));
        end
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void report_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------
    // Driver: one transaction per accept, random gap after each
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic nxt_valid;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !o_in_stall) decode_item(in_item);
            if (!(in_valid && o_in_stall)) begin
                nxt_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (item_q.size() > 0 && (!hold_q[0] || decoded_q.size() == 0)) begin
                    in_item <= item_q.pop_front();
                    void'(hold_q.pop_front());
                    nxt_valid = 1'b1;
                    if (calm_in > 0) begin
                        calm_in  <= calm_in - 1;
                        gap_left <= 0;
                    end else begin
                        gap_left <= idle_len();
                        if ($urandom_range(0, 39) == 0) calm_in <= $urandom_range(15, 40);
                    end
                end
                in_valid <= nxt_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each decoded transaction, drive random stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        upd_pkg::t_out_item want;
        int                 n;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (decoded_q.size() == 0) begin
                    report_error($sformatf("unexpected output: byte %02h last %0b",
                                           o_out_item.out_byte, o_out_item.out_last));
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_item.out_byte !== want.out_byte ||
                        o_out_item.out_last !== want.out_last) begin
                        report_error($sformatf(
                            "mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                            want.out_byte, want.out_last,
                            o_out_item.out_byte, o_out_item.out_last));
                    end
                end
            end
            if (stall_left > 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (calm_out > 0) begin
                out_stall <= 1'b0;
                calm_out  <= calm_out - 1;
            end else begin
                n = idle_len();
                out_stall  <= (n > 0);
                stall_left <= (n > 0) ? n - 1 : 0;
                if ($urandom_range(0, 59) == 0) calm_out <= $urandom_range(20, 60);
            end
        end
    end

    // Watchdog: no transaction on either side for too long
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cyc <= 0;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int random_cnt;
        int before_cnt;

        // plus, escapes in both cases, raw extremes
        add_text("%4a+%FF", 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        // broken escapes, double percent, flush of a lone percent
        add_text("%g%5:%%41%", 1'b1);
        // flush of percent plus digit, plus as last byte, digit boundary
        add_text("%b", 1'b1);
        add_text("+", 1'b1);
        add_text("%3/", 1'b1);

        random_cnt = 0;
        while (random_cnt < RANDOM_ITEMS) begin
            before_cnt = item_q.size();
            // wait for the pipeline to drain at the start and midway
            add_random_string(random_cnt == 0 ||
                              (random_cnt >= RANDOM_ITEMS / 2 &&
                               random_cnt < RANDOM_ITEMS / 2 + 3));
            random_cnt += item_q.size() - before_cnt;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (item_q.size() != 0 || in_valid || decoded_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
